@@ src/pcd_pkg.sv @@
// shared types, constants and helpers for the prefix-coded lz window decoder
package pcd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W      = 26;
    localparam int LEN_W        = 9;
    localparam int DIST_W       = 13;
    localparam int RAW_W        = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // copy distance bases from the offset prefix code
    localparam logic [DIST_W-1:0] DIST_NEAR = 13'h0001;
    localparam logic [DIST_W-1:0] DIST_101  = 13'h0101;
    localparam logic [DIST_W-1:0] DIST_201  = 13'h0201;
    localparam logic [DIST_W-1:0] DIST_401  = 13'h0401;
    localparam logic [DIST_W-1:0] DIST_501  = 13'h0501;
    localparam logic [DIST_W-1:0] DIST_601  = 13'h0601;
    localparam logic [DIST_W-1:0] DIST_701  = 13'h0701;
    localparam logic [DIST_W-1:0] DIST_801  = 13'h0801;
    localparam logic [DIST_W-1:0] DIST_A01  = 13'h0A01;
    localparam logic [DIST_W-1:0] DIST_C01  = 13'h0C01;
    localparam logic [DIST_W-1:0] DIST_E01  = 13'h0E01;
    localparam logic [DIST_W-1:0] DIST_STEP = 13'h0100;

    typedef enum logic [16:0] {
        PH_CMD     = 17'h00001,
        PH_LIT     = 17'h00002,
        PH_LEN2    = 17'h00004,
        PH_LEN0A   = 17'h00008,
        PH_LEN0B   = 17'h00010,
        PH_LEN2A   = 17'h00020,
        PH_LEN2B   = 17'h00040,
        PH_RAWCNT  = 17'h00080,
        PH_RAW     = 17'h00100,
        PH_LEN3A   = 17'h00200,
        PH_LEN3B   = 17'h00400,
        PH_OFSFLAG = 17'h00800,
        PH_OFS2    = 17'h01000,
        PH_OFS2B   = 17'h02000,
        PH_OFS3B   = 17'h04000,
        PH_OFSBIT  = 17'h08000,
        PH_LOW     = 17'h10000
    } t_phase;

    typedef struct packed {
        logic load;
        logic dec;
        logic cp_rd;
        logic cp_wr;
        logic emit_mid;
        logic emit_end;
    } t_cmd;

    typedef struct packed {
        logic can_dec;
        logic copy_go;
        logic len_one;
        logic pack_seven;
        logic pack_empty;
        logic out_free;
        logic done;
    } t_status;

    function automatic logic [3:0] need_bits(input t_phase ph);
        logic [3:0] n;
        unique case (ph)
            PH_LIT, PH_RAW, PH_LEN3B, PH_LOW:         n = 4'd8;
            PH_RAWCNT:                                n = 4'd4;
            PH_LEN2, PH_OFS2, PH_OFS2B, PH_OFS3B:     n = 4'd2;
            default:                                  n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

@@ src/prefix_coded_lz_window_decoder.sv @@
// top level: prefix-coded lz window decoder
// Each request (one compressed byte) is loaded and then decoded one prefix field at a time;
// each copied byte is a window read then a write on the single-port history memory, and
// each full group of eight is handed out in the middle of a copy. The last result of a
// request goes out in its closing cycle, and a result still waiting in the output
// register holds things up until it is taken. The history window needs no clearing
// pass: writes go in order, so entries not yet written are known from the write
// pointer and read as zero. A finished result waits in the output register while the
// next request is taken. After the end of stream, requests are accepted and dropped
// until reset.
module prefix_coded_lz_window_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_stream_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [63:0]                  o_out_bytes,
    output logic [3:0]                   o_byte_count,
    output logic                         o_last_of_run,
    output logic                         o_finished,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pcd_pkg::COUNT_W-1:0]  i_decompressed_size
);

    pcd_pkg::t_cmd    cmd;
    pcd_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    pcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pcd_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_stream_byte       (i_stream_byte),
        .i_cfg_valid         (i_cfg_valid),
        .i_decompressed_size (i_decompressed_size),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_out_bytes         (o_out_bytes),
        .o_byte_count        (o_byte_count),
        .o_last_of_run       (o_last_of_run),
        .o_finished          (o_finished)
    );

endmodule

@@ src/pcd_ctrl.sv @@
// sequencing state machine: decode steps, window copy and result hand-off
module pcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcd_pkg::t_status i_status,
    output pcd_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_CPRD   = 6'b000100,
        S_CPWR   = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_END    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                // requests after the end of stream are taken and dropped
                if (i_in_valid && !i_status.done) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.can_dec) begin
                    o_cmd.dec = 1'b1;
                    if (i_status.copy_go) begin
                        n_state = S_CPRD;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_CPRD: begin
                o_cmd.cp_rd = 1'b1;
                n_state     = S_CPWR;
            end
            S_CPWR: begin
                o_cmd.cp_wr = 1'b1;
                if (i_status.len_one) begin
                    n_state = S_DECODE;
                end else if (i_status.pack_seven) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_CPRD;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_mid = 1'b1;
                    n_state        = S_CPRD;
                end
            end
            S_END: begin
                if (i_status.pack_empty) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/pcd_datapath.sv @@
// bit buffer, prefix decoder, history window, byte packer and result register
module pcd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcd_pkg::t_cmd                i_cmd,
    output pcd_pkg::t_status             o_status,
    input  logic [7:0]                   i_stream_byte,
    input  logic                         i_cfg_valid,
    input  logic [pcd_pkg::COUNT_W-1:0]  i_decompressed_size,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [63:0]                  o_out_bytes,
    output logic [3:0]                   o_byte_count,
    output logic                         o_last_of_run,
    output logic                         o_finished
);

    localparam int AW = pcd_pkg::WIN_AW;

    logic [7:0]                  r_win [pcd_pkg::WINDOW_DEPTH];
    logic [7:0]                  r_rd_q;
    logic                        r_rd_ok;
    logic [AW-1:0]               r_wp;
    logic                        r_wrapped;
    logic [pcd_pkg::COUNT_W-1:0] r_count;
    logic [pcd_pkg::COUNT_W-1:0] r_size;
    logic [15:0]                 r_buf,  n_buf;
    logic [4:0]                  r_held, n_held;
    pcd_pkg::t_phase             r_phase, n_phase;
    logic [pcd_pkg::LEN_W-1:0]   r_len,  n_len;
    logic [pcd_pkg::DIST_W-1:0]  r_dist, n_dist;
    logic [pcd_pkg::RAW_W-1:0]   r_raw,  n_raw;
    logic                        r_done, n_done;
    logic                        r_fin_pred;
    logic [63:0]                 r_pbytes;
    logic [3:0]                  r_pcnt;
    logic                        r_ov;
    logic [63:0]                 r_obytes;
    logic [3:0]                  r_ocnt;
    logic                        r_olast;
    logic                        r_ofin;

    logic [3:0]           need;
    logic [7:0]           x;
    logic [7:0]           mask;
    logic                 size_hit;
    logic                 can_dec;
    logic                 lit_put;
    logic                 put;
    logic [7:0]           put_byte;
    logic [AW+12:0]       src_diff;
    logic [AW-1:0]        src_addr;
    logic [15:0]          in_sh;
    logic                 out_free;
    logic                 emit;

    assign need     = pcd_pkg::need_bits(r_phase);
    assign mask     = 8'((9'd1 << need) - 9'd1);
    assign x        = r_buf[7:0] & mask;
    assign size_hit = (r_phase == pcd_pkg::PH_CMD) && (r_count >= r_size);
    assign can_dec  = !r_done && (size_hit || (r_held >= {1'b0, need}));
    assign in_sh    = {8'h00, i_stream_byte} << r_held[2:0];
    assign out_free = !r_ov || i_out_ready;
    assign emit     = i_cmd.emit_mid || i_cmd.emit_end;

    // field decode, one prefix field per cycle
    always_comb begin
        n_buf   = r_buf;
        n_held  = r_held;
        n_phase = r_phase;
        n_len   = r_len;
        n_dist  = r_dist;
        n_raw   = r_raw;
        n_done  = r_done;
        lit_put = 1'b0;
        if (i_cmd.load) begin
            n_buf  = r_buf | in_sh;
            n_held = {2'b00, r_held[2:0]} + 5'd8;
        end else if (i_cmd.dec) begin
            if (size_hit) begin
                n_done = 1'b1;
                n_buf  = '0;
                n_held = '0;
            end else begin
                n_buf  = r_buf >> need;
                n_held = r_held - {1'b0, need};
                unique case (r_phase)
                    pcd_pkg::PH_CMD: begin
                        n_phase = x[0] ? pcd_pkg::PH_LEN2 : pcd_pkg::PH_LIT;
                    end
                    pcd_pkg::PH_LIT: begin
                        lit_put = 1'b1;
                        n_phase = pcd_pkg::PH_CMD;
                    end
                    pcd_pkg::PH_LEN2: begin
                        case (x[1:0])
                            2'd0: begin
                                n_len   = 9'd4;
                                n_phase = pcd_pkg::PH_LEN0A;
                            end
                            2'd1: begin
                                n_len   = 9'd2;
                                n_dist  = pcd_pkg::DIST_NEAR;
                                n_phase = pcd_pkg::PH_LOW;
                            end
                            2'd2: n_phase = pcd_pkg::PH_LEN2A;
                            default: begin
                                n_len   = 9'd3;
                                n_phase = pcd_pkg::PH_LEN3A;
                            end
                        endcase
                    end
                    pcd_pkg::PH_LEN0A: begin
                        n_phase = x[0] ? pcd_pkg::PH_LEN0B : pcd_pkg::PH_OFSFLAG;
                    end
                    pcd_pkg::PH_LEN0B: begin
                        n_len   = x[0] ? 9'd7 : 9'd6;
                        n_phase = pcd_pkg::PH_OFSFLAG;
                    end
                    pcd_pkg::PH_LEN2A: begin
                        if (x[0]) begin
                            n_phase = pcd_pkg::PH_LEN2B;
                        end else begin
                            n_len   = 9'd5;
                            n_phase = pcd_pkg::PH_OFSFLAG;
                        end
                    end
                    pcd_pkg::PH_LEN2B: begin
                        if (x[0]) begin
                            n_phase = pcd_pkg::PH_RAWCNT;
                        end else begin
                            n_len   = 9'd8;
                            n_phase = pcd_pkg::PH_OFSFLAG;
                        end
                    end
                    pcd_pkg::PH_RAWCNT: begin
                        // (count + 3) words of four bytes
                        n_raw   = {({1'b0, x[3:0]} + 5'd3), 2'b00};
                        n_phase = pcd_pkg::PH_RAW;
                    end
                    pcd_pkg::PH_RAW: begin
                        lit_put = 1'b1;
                        if (r_raw != '0) begin
                            n_raw = r_raw - 7'd1;
                        end
                        if (n_raw == '0) begin
                            n_phase = pcd_pkg::PH_CMD;
                        end
                    end
                    pcd_pkg::PH_LEN3A: begin
                        n_phase = x[0] ? pcd_pkg::PH_LEN3B : pcd_pkg::PH_OFSFLAG;
                    end
                    pcd_pkg::PH_LEN3B: begin
                        if (x == 8'd0) begin
                            // terminator
                            n_done  = 1'b1;
                            n_buf   = '0;
                            n_held  = '0;
                            n_phase = pcd_pkg::PH_CMD;
                        end else begin
                            n_len   = {1'b0, x} + 9'd8;
                            n_phase = pcd_pkg::PH_OFSFLAG;
                        end
                    end
                    pcd_pkg::PH_OFSFLAG: begin
                        if (x[0]) begin
                            n_phase = pcd_pkg::PH_OFS2;
                        end else begin
                            n_dist  = pcd_pkg::DIST_NEAR;
                            n_phase = pcd_pkg::PH_LOW;
                        end
                    end
                    pcd_pkg::PH_OFS2: begin
                        case (x[1:0])
                            2'd0: begin
                                n_dist  = pcd_pkg::DIST_201;
                                n_phase = pcd_pkg::PH_OFSBIT;
                            end
                            2'd1: begin
                                n_dist  = pcd_pkg::DIST_101;
                                n_phase = pcd_pkg::PH_LOW;
                            end
                            2'd2:    n_phase = pcd_pkg::PH_OFS2B;
                            default: n_phase = pcd_pkg::PH_OFS3B;
                        endcase
                    end
                    pcd_pkg::PH_OFS2B: begin
                        case (x[1:0])
                            2'd0: begin
                                n_dist  = pcd_pkg::DIST_801;
                                n_phase = pcd_pkg::PH_OFSBIT;
                            end
                            2'd1: begin
                                n_dist  = pcd_pkg::DIST_A01;
                                n_phase = pcd_pkg::PH_OFSBIT;
                            end
                            2'd2: begin
                                n_dist  = pcd_pkg::DIST_401;
                                n_phase = pcd_pkg::PH_LOW;
                            end
                            default: begin
                                n_dist  = pcd_pkg::DIST_501;
                                n_phase = pcd_pkg::PH_LOW;
                            end
                        endcase
                    end
                    pcd_pkg::PH_OFS3B: begin
                        case (x[1:0])
                            2'd0: begin
                                n_dist  = pcd_pkg::DIST_C01;
                                n_phase = pcd_pkg::PH_OFSBIT;
                            end
                            2'd1: begin
                                n_dist  = pcd_pkg::DIST_E01;
                                n_phase = pcd_pkg::PH_OFSBIT;
                            end
                            2'd2: begin
                                n_dist  = pcd_pkg::DIST_601;
                                n_phase = pcd_pkg::PH_LOW;
                            end
                            default: begin
                                n_dist  = pcd_pkg::DIST_701;
                                n_phase = pcd_pkg::PH_LOW;
                            end
                        endcase
                    end
                    pcd_pkg::PH_OFSBIT: begin
                        if (x[0]) begin
                            n_dist = r_dist + pcd_pkg::DIST_STEP;
                        end
                        n_phase = pcd_pkg::PH_LOW;
                    end
                    pcd_pkg::PH_LOW: begin
                        n_dist  = r_dist + {5'b00000, x};
                        n_phase = pcd_pkg::PH_CMD;
                    end
                    default: begin
                        n_phase = pcd_pkg::PH_CMD;
                    end
                endcase
            end
        end else if (i_cmd.cp_wr) begin
            n_len = r_len - 9'd1;
        end
    end

    assign put      = (i_cmd.dec && lit_put) || i_cmd.cp_wr;
    assign put_byte = i_cmd.cp_wr ? (r_rd_ok ? r_rd_q : 8'h00) : x;

    // copy source, modulo the window; entries never written read as zero
    assign src_diff = {13'b0, r_wp} - {{AW{1'b0}}, r_dist};
    assign src_addr = src_diff[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (put) begin
            r_win[r_wp] <= put_byte;
        end
        if (i_cmd.cp_rd) begin
            r_rd_q  <= r_win[src_addr];
            r_rd_ok <= r_wrapped || (src_addr < r_wp);
        end
        if (emit) begin
            r_obytes <= r_pbytes;
            r_ocnt   <= r_pcnt;
            r_olast  <= i_cmd.emit_end;
            r_ofin   <= i_cmd.emit_end ? r_done : r_fin_pred;
        end
        if (i_cmd.dec && !size_hit && r_phase == pcd_pkg::PH_LOW) begin
            // stop after the copy is decided up front so full groups carry it
            r_fin_pred <= ({1'b0, r_count} + {{(pcd_pkg::COUNT_W-pcd_pkg::LEN_W+1){1'b0}}, r_len})
                          >= {1'b0, r_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_count   <= '0;
            r_size    <= '0;
            r_buf     <= '0;
            r_held    <= '0;
            r_phase   <= pcd_pkg::PH_CMD;
            r_len     <= '0;
            r_dist    <= '0;
            r_raw     <= '0;
            r_done    <= 1'b0;
            r_pbytes  <= '0;
            r_pcnt    <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_decompressed_size;
            end
            r_buf   <= n_buf;
            r_held  <= n_held;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_dist  <= n_dist;
            r_raw   <= n_raw;
            r_done  <= n_done;
            if (put) begin
                r_wp <= r_wp + 1'b1;
                if (r_wp == AW'(pcd_pkg::WINDOW_DEPTH - 1)) begin
                    r_wrapped <= 1'b1;
                end
                if (r_count != pcd_pkg::COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
                r_pbytes[{r_pcnt[2:0], 3'b000} +: 8] <= put_byte;
                r_pcnt <= r_pcnt + 4'd1;
            end else if (emit) begin
                r_pbytes <= '0;
                r_pcnt   <= '0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.can_dec    = can_dec;
        o_status.copy_go    = can_dec && !size_hit && (r_phase == pcd_pkg::PH_LOW);
        o_status.len_one    = (r_len == 9'd1);
        o_status.pack_seven = (r_pcnt == 4'd7);
        o_status.pack_empty = (r_pcnt == 4'd0);
        o_status.out_free   = out_free;
        o_status.done       = r_done;
    end

    assign o_out_valid   = r_ov;
    assign o_out_bytes   = r_obytes;
    assign o_byte_count  = r_ocnt;
    assign o_last_of_run = r_olast;
    assign o_finished    = r_ofin;

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cp_wr |-> r_len != '0)
        else $error("copy write with no bytes left");
    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_mid |-> r_pcnt == 4'd8)
        else $error("partial group handed out inside a copy");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result register overwritten");
    a_load_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> r_held < 5'd8)
        else $error("bit buffer overfull at new request");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("end of stream flag dropped");

endmodule
